@@ hw/rtl/sde_pkg.sv @@
// Package with shared types, constants and command codes for the deque engine.
package sde_pkg;

  localparam int Capacity = 64;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);
  localparam int TagW = 32;

  localparam logic [3:0] CMD_PUSH_FRONT = 4'd0;
  localparam logic [3:0] CMD_PUSH_BACK  = 4'd1;
  localparam logic [3:0] CMD_INSERT_AT  = 4'd2;
  localparam logic [3:0] CMD_POP_FRONT  = 4'd3;
  localparam logic [3:0] CMD_POP_BACK   = 4'd4;
  localparam logic [3:0] CMD_REMOVE_AT  = 4'd5;
  localparam logic [3:0] CMD_ROTATE     = 4'd6;
  localparam logic [3:0] CMD_REV_PREFIX = 4'd7;
  localparam logic [3:0] CMD_REV_SUFFIX = 4'd8;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [3:0]  command;
    logic [31:0] element_value;
    logic [6:0]  position;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_value;
    logic [6:0]  count_after;
  } rsp_t;

  // Datapath operation selects issued by the controller.
  typedef struct packed {
    logic latch;      // capture the command and compute offsets
    logic rd_a;       // read ring slot at offset a
    logic rd_b;       // read ring slot at offset b
    logic hold_a;     // save read data into temp a
    logic hold_b;     // save read data into temp b
    logic wr_a_tmpb;  // write temp b to offset a
    logic wr_b_tmpa;  // write temp a to offset b
    logic wr_a_val;   // write the new tag to offset a
    logic wr_a_tmpa;  // write temp a to offset a
    logic step_down;  // a <= a - 1, b <= b - 1
    logic step_up;    // a <= a + 1, b <= b + 1
    logic step_in;    // a <= a + 1, b <= b - 1
    logic grab_res;   // save read data as result
    logic commit;     // update head and count
    logic emit;       // drive the result
  } ctl_t;

  typedef struct packed {
    logic [3:0] command;
    logic [1:0] status;
    logic       a_lt_b;   // a below b; inserts: insert point below a; removals: b below count and a nonzero
    logic       a_eq_b;
  } sts_t;

endpackage

@@ hw/rtl/sde_ram.sv @@
// Generic single-port RAM with a registered read.
module sde_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // One access per cycle: registered read, with a write when we is high.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hw/rtl/sde_datapath.sv @@
// Datapath of the deque engine: ring store, offsets, temps and result.
module sde_datapath (
  input  logic          clk,
  input  logic          rst,
  input  sde_pkg::cmd_t cmd_in,
  input  sde_pkg::ctl_t ctl,
  output sde_pkg::sts_t sts,
  output sde_pkg::rsp_t result
);

  localparam int IdxW = sde_pkg::IdxW;
  localparam int CntW = sde_pkg::CntW;

  sde_pkg::cmd_t cmd;
  logic [IdxW-1:0] head;
  logic [CntW-1:0] count;
  logic [CntW-1:0] off_a;
  logic [CntW-1:0] off_b;
  logic [31:0] tmp_a;
  logic [31:0] tmp_b;
  logic [31:0] res;
  logic [1:0] status;
  logic [1:0] status_next;
  logic [CntW-1:0] a_next;
  logic [CntW-1:0] b_next;
  logic [CntW-1:0] off;
  logic [CntW:0] slot_sum;
  logic [IdxW-1:0] addr;
  logic we;
  logic [31:0] wdata;
  logic [31:0] rdata;

  // Status checks and starting offsets of a new command.
  always_comb begin
    status_next = sde_pkg::ST_OK;
    a_next = '0;
    b_next = '0;
    unique case (cmd_in.command)
      sde_pkg::CMD_PUSH_FRONT, sde_pkg::CMD_PUSH_BACK, sde_pkg::CMD_INSERT_AT: begin
        // a walks down from count, b = a - 1; the insert point stops it.
        a_next = count;
        b_next = count - CntW'(1);
        if (count == CntW'(sde_pkg::Capacity)) begin
          status_next = sde_pkg::ST_FULL;
        end else if (cmd_in.command == sde_pkg::CMD_INSERT_AT &&
                     cmd_in.position > count) begin
          status_next = sde_pkg::ST_RANGE;
        end
      end
      sde_pkg::CMD_POP_FRONT, sde_pkg::CMD_POP_BACK, sde_pkg::CMD_REMOVE_AT: begin
        if (cmd_in.command == sde_pkg::CMD_REMOVE_AT) begin
          a_next = cmd_in.position;
        end else if (cmd_in.command == sde_pkg::CMD_POP_BACK) begin
          a_next = count - CntW'(1);
        end
        b_next = a_next + CntW'(1);
        if (count == '0) begin
          status_next = sde_pkg::ST_EMPTY;
        end else if (cmd_in.command == sde_pkg::CMD_REMOVE_AT &&
                     cmd_in.position >= count) begin
          status_next = sde_pkg::ST_RANGE;
        end
      end
      sde_pkg::CMD_ROTATE: begin
        a_next = '0;
        b_next = count;
        if (count == '0) begin
          status_next = sde_pkg::ST_EMPTY;
        end
      end
      sde_pkg::CMD_REV_PREFIX, sde_pkg::CMD_REV_SUFFIX: begin
        if (cmd_in.command == sde_pkg::CMD_REV_PREFIX) begin
          a_next = '0;
          b_next = cmd_in.position - CntW'(1);
        end else begin
          a_next = count - cmd_in.position;
          b_next = count - CntW'(1);
        end
        if (cmd_in.position > count || cmd_in.position == '0) begin
          status_next = (cmd_in.position > count) ? sde_pkg::ST_RANGE : sde_pkg::ST_OK;
          a_next = '0;
          b_next = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Insert loop stops once a reaches the insert position.
  logic [CntW-1:0] ins_pos;
  always_comb begin
    case (cmd.command)
      sde_pkg::CMD_PUSH_FRONT: ins_pos = '0;
      sde_pkg::CMD_PUSH_BACK:  ins_pos = count;
      default:                 ins_pos = cmd.position;
    endcase
  end

  // Compare signals for the controller; for inserts a is compared with the insert point.
  // A removal at the front only moves the head, so it never closes a gap.
  always_comb begin
    sts.command = cmd.command;
    sts.status  = status;
    if (cmd.command == sde_pkg::CMD_PUSH_FRONT || cmd.command == sde_pkg::CMD_PUSH_BACK ||
        cmd.command == sde_pkg::CMD_INSERT_AT) begin
      sts.a_lt_b = ins_pos < off_a;
      sts.a_eq_b = ins_pos == off_a;
    end else if (cmd.command == sde_pkg::CMD_REMOVE_AT ||
                 cmd.command == sde_pkg::CMD_POP_BACK ||
                 cmd.command == sde_pkg::CMD_POP_FRONT) begin
      sts.a_lt_b = (off_b < count) && (off_a != '0);
      sts.a_eq_b = 1'b0;
    end else begin
      sts.a_lt_b = off_a < off_b;
      sts.a_eq_b = off_a == off_b;
    end
  end

  // Ring slot of the selected offset.
  always_comb begin
    off = (ctl.rd_b || ctl.wr_b_tmpa) ? off_b : off_a;
    slot_sum = {1'b0, (CntW)'(head)} + {1'b0, off};
    if (slot_sum >= (CntW + 1)'(sde_pkg::Capacity)) begin
      slot_sum = slot_sum - (CntW + 1)'(sde_pkg::Capacity);
    end
    addr = slot_sum[IdxW-1:0];
    we = ctl.wr_a_tmpb | ctl.wr_b_tmpa | ctl.wr_a_val | ctl.wr_a_tmpa;
    if (ctl.wr_a_val) begin
      wdata = cmd.element_value;
    end else if (ctl.wr_b_tmpa || ctl.wr_a_tmpa) begin
      wdata = tmp_a;
    end else begin
      wdata = tmp_b;
    end
  end

  sde_ram #(.Width(sde_pkg::TagW), .Depth(sde_pkg::Capacity)) u_ram (
    .clk  (clk),
    .we   (we),
    .addr (addr),
    .wdata(wdata),
    .rdata(rdata)
  );

  // Command capture, offsets and temps.
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd    <= cmd_in;
      status <= status_next;
      off_a  <= a_next;
      off_b  <= b_next;
      res    <= '0;
    end else begin
      if (ctl.step_down) begin
        off_a <= off_a - CntW'(1);
        off_b <= off_b - CntW'(1);
      end
      if (ctl.step_up) begin
        off_a <= off_a + CntW'(1);
        off_b <= off_b + CntW'(1);
      end
      if (ctl.step_in) begin
        off_a <= off_a + CntW'(1);
        off_b <= off_b - CntW'(1);
      end
    end
    if (ctl.hold_a) begin
      tmp_a <= rdata;
    end
    if (ctl.hold_b) begin
      tmp_b <= rdata;
    end
    if (ctl.grab_res) begin
      res <= rdata;
    end
  end

  // Head and count update on a successful command.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (ctl.commit && status == sde_pkg::ST_OK) begin
      case (cmd.command)
        sde_pkg::CMD_PUSH_FRONT, sde_pkg::CMD_PUSH_BACK, sde_pkg::CMD_INSERT_AT: begin
          count <= count + CntW'(1);
        end
        sde_pkg::CMD_POP_FRONT, sde_pkg::CMD_POP_BACK, sde_pkg::CMD_REMOVE_AT: begin
          count <= count - CntW'(1);
          if (cmd.command == sde_pkg::CMD_POP_FRONT ||
              (cmd.command == sde_pkg::CMD_REMOVE_AT && cmd.position == '0)) begin
            head <= head + IdxW'(1);
          end
        end
        sde_pkg::CMD_ROTATE: begin
          head <= head + IdxW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    result.status       = status;
    result.result_value = res;
    result.count_after  = count;
  end

endmodule

@@ hw/rtl/sde_ctrl.sv @@
// Controller state machine that sequences memory accesses for each command.
module sde_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  sde_pkg::sts_t sts,
  output sde_pkg::ctl_t ctl,
  output logic          busy,
  output logic          strobe
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_SH_RD  = 4'd2;  // shift: read source at b
  localparam logic [3:0] S_SH_WR  = 4'd3;  // shift: hold the read data in temp b
  localparam logic [3:0] S_INS_WR = 4'd4;
  localparam logic [3:0] S_RES_RD = 4'd5;  // read removed element
  localparam logic [3:0] S_RES_GR = 4'd6;
  localparam logic [3:0] S_SW_RA  = 4'd7;  // swap: read a
  localparam logic [3:0] S_SW_RB  = 4'd8;  // grab the result, hold a
  localparam logic [3:0] S_SW_HB  = 4'd9;  // swap: hold a, read b
  localparam logic [3:0] S_SW_WA  = 4'd10;
  localparam logic [3:0] S_SW_WB  = 4'd11;
  localparam logic [3:0] S_ROT_WR = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;
  logic is_ins;
  logic is_rem;
  logic is_rev;

  always_comb begin
    is_ins = sts.command == sde_pkg::CMD_PUSH_FRONT || sts.command == sde_pkg::CMD_PUSH_BACK ||
             sts.command == sde_pkg::CMD_INSERT_AT;
    is_rem = sts.command == sde_pkg::CMD_POP_FRONT || sts.command == sde_pkg::CMD_POP_BACK ||
             sts.command == sde_pkg::CMD_REMOVE_AT;
    is_rev = sts.command == sde_pkg::CMD_REV_PREFIX || sts.command == sde_pkg::CMD_REV_SUFFIX;
  end

  // Next state and command outputs.
  always_comb begin
    ctl = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.latch = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.status != sde_pkg::ST_OK) begin
          state_next = S_DONE;
        end else if (is_ins) begin
          state_next = sts.a_eq_b ? S_INS_WR : S_SH_RD;
        end else if (is_rem || sts.command == sde_pkg::CMD_ROTATE) begin
          state_next = S_RES_RD;
        end else if (is_rev) begin
          state_next = sts.a_lt_b ? S_SW_RA : S_DONE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SH_RD: begin
        ctl.rd_b = 1'b1;
        state_next = S_SH_WR;
      end
      S_SH_WR: begin
        ctl.hold_b = 1'b1;
        state_next = S_SW_WA;
      end
      S_SW_WA: begin
        // Write the held value to a; inserts and removals then step the offsets.
        ctl.wr_a_tmpb = 1'b1;
        if (is_ins) begin
          ctl.step_down = 1'b1;
          state_next = S_INS_WR;
          if (!sts.a_lt_b || sts.a_eq_b) begin
            state_next = S_INS_WR;
          end
        end else if (is_rem) begin
          ctl.step_up = 1'b1;
          state_next = S_RES_GR;
        end else begin
          state_next = S_SW_WB;
        end
      end
      S_INS_WR: begin
        if (sts.a_eq_b) begin
          ctl.wr_a_val = 1'b1;
          ctl.commit = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_SH_RD;
        end
      end
      S_RES_RD: begin
        ctl.rd_a = 1'b1;
        state_next = S_RES_GR;
        if (sts.command == sde_pkg::CMD_ROTATE || is_rem) begin
          state_next = S_SW_RB;
        end
      end
      S_SW_RB: begin
        // Removed or rotated element is now on the read data.
        ctl.grab_res = 1'b1;
        ctl.hold_a = 1'b1;
        if (sts.command == sde_pkg::CMD_ROTATE) begin
          state_next = S_ROT_WR;
        end else begin
          state_next = S_RES_GR;
        end
      end
      S_RES_GR: begin
        // Close the gap after a removal while b is below count.
        if (sts.command == sde_pkg::CMD_POP_FRONT ||
            (sts.command == sde_pkg::CMD_REMOVE_AT && !sts.a_lt_b) || !sts.a_lt_b) begin
          ctl.commit = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_SH_RD;
        end
      end
      S_ROT_WR: begin
        ctl.wr_b_tmpa = 1'b1;
        ctl.commit = 1'b1;
        state_next = S_DONE;
      end
      S_SW_RA: begin
        ctl.rd_a = 1'b1;
        state_next = S_SW_HB;
      end
      S_SW_HB: begin
        ctl.hold_a = 1'b1;
        ctl.rd_b = 1'b1;
        state_next = S_SH_WR;
      end
      S_SW_WB: begin
        ctl.wr_b_tmpa = 1'b1;
        ctl.step_in = 1'b1;
        state_next = S_DONE;
        if (sts.a_lt_b) begin
          state_next = S_IDLE;
        end
        state_next = S_DECODE;
      end
      S_DONE: begin
        ctl.emit = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = state != S_IDLE;
  assign strobe = ctl.emit;

endmodule

@@ hw/rtl/sequence_deque_engine.sv @@
// Top level of the deque engine: controller and datapath.
//
// Channel   Direction  Handshake       Payload
// command   in         start / busy    cmd (sde_pkg::cmd_t)
// result    out        done strobe     rsp (sde_pkg::rsp_t)
//
// Each shifted entry and each swapped pair adds RAM accesses through the single
// RAM port, so the worst case is an insert at the front of 63 entries. A new
// command is taken only while busy is low, after the result of the last one.
// Synchronous reset empties the deque; the store itself is not cleared.
// The result is shown for one cycle and cannot be stalled.
module sequence_deque_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  sde_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done,
  output sde_pkg::rsp_t rsp
);

  sde_pkg::ctl_t ctl;
  sde_pkg::sts_t sts;

  sde_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy),
    .strobe(done)
  );

  sde_datapath u_dp (
    .clk   (clk),
    .rst   (rst),
    .cmd_in(cmd),
    .ctl   (ctl),
    .sts   (sts),
    .result(rsp)
  );

endmodule

@@ tb/tb_sequence_deque_engine.sv @@
// Self-checking testbench for the deque engine: directed table, fill to capacity, then random commands.
`timescale 1ns / 100ps

module tb_sequence_deque_engine;

  localparam int NumRandom = 650;

  logic           clk;
  logic           rst;
  logic           start;
  sde_pkg::cmd_t  cmd;
  logic           busy;
  logic           done;
  sde_pkg::rsp_t  rsp;

  sequence_deque_engine u_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .cmd  (cmd),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  // Predictor state: a queue with the front at index 0.
  logic [31:0]    deque_q[$];
  sde_pkg::rsp_t  expected_rsp_q[$];
  int             error_count;
  int             rsp_count;
  int             status_seen[4];

  // Directed stimulus row; check_rsp marks rows whose result is typed in.
  typedef struct {
    sde_pkg::cmd_t cmd;
    logic          check_rsp;
    sde_pkg::rsp_t rsp;
  } dir_row_t;

  // Compute the result of one command and advance the predicted deque.
  function automatic sde_pkg::rsp_t predict_deque(sde_pkg::cmd_t c);
    sde_pkg::rsp_t r;
    int n;
    int p;
    logic [31:0] t;
    n = deque_q.size();
    p = c.position;
    r.status = sde_pkg::ST_OK;
    r.result_value = '0;
    case (c.command)
      sde_pkg::CMD_PUSH_FRONT, sde_pkg::CMD_PUSH_BACK, sde_pkg::CMD_INSERT_AT: begin
        if (n >= sde_pkg::Capacity) begin
          r.status = sde_pkg::ST_FULL;
        end else if (c.command == sde_pkg::CMD_PUSH_FRONT) begin
          deque_q.push_front(c.element_value);
        end else if (c.command == sde_pkg::CMD_PUSH_BACK) begin
          deque_q.push_back(c.element_value);
        end else if (p > n) begin
          r.status = sde_pkg::ST_RANGE;
        end else begin
          deque_q.insert(p, c.element_value);
        end
      end
      sde_pkg::CMD_POP_FRONT, sde_pkg::CMD_POP_BACK, sde_pkg::CMD_REMOVE_AT: begin
        if (n == 0) begin
          r.status = sde_pkg::ST_EMPTY;
        end else if (c.command == sde_pkg::CMD_POP_FRONT) begin
          r.result_value = deque_q.pop_front();
        end else if (c.command == sde_pkg::CMD_POP_BACK) begin
          r.result_value = deque_q.pop_back();
        end else if (p >= n) begin
          r.status = sde_pkg::ST_RANGE;
        end else begin
          r.result_value = deque_q[p];
          deque_q.delete(p);
        end
      end
      sde_pkg::CMD_ROTATE: begin
        if (n == 0) begin
          r.status = sde_pkg::ST_EMPTY;
        end else begin
          r.result_value = deque_q.pop_front();
          deque_q.push_back(r.result_value);
        end
      end
      sde_pkg::CMD_REV_PREFIX, sde_pkg::CMD_REV_SUFFIX: begin
        if (p > n) begin
          r.status = sde_pkg::ST_RANGE;
        end else begin
          for (int i = 0; i < p / 2; i++) begin
            int a;
            int b;
            a = (c.command == sde_pkg::CMD_REV_PREFIX) ? i : n - p + i;
            b = (c.command == sde_pkg::CMD_REV_PREFIX) ? p - 1 - i : n - 1 - i;
            t = deque_q[a];
            deque_q[a] = deque_q[b];
            deque_q[b] = t;
          end
        end
      end
      default: ;
    endcase
    r.count_after = 7'(deque_q.size());
    return r;
  endfunction

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result checker: every strobed transfer is matched to the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_rsp_q.size() == 0) begin
        $error("unexpected result: %p", rsp);
        error_count++;
      end else begin
        sde_pkg::rsp_t e;
        e = expected_rsp_q.pop_front();
        rsp_count++;
        status_seen[e.status]++;
        if (rsp.status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, rsp.status);
          error_count++;
        end
        if (rsp.result_value !== e.result_value) begin
          $error("result_value: expected %h, actual %h", e.result_value, rsp.result_value);
          error_count++;
        end
        if (rsp.count_after !== e.count_after) begin
          $error("count_after: expected %0d, actual %0d", e.count_after, rsp.count_after);
          error_count++;
        end
      end
    end
  end

  // Issue one command: wait until idle, hold start through the accepting edge.
  task automatic send_command(sde_pkg::cmd_t c, logic check_rsp, sde_pkg::rsp_t typed_rsp);
    sde_pkg::rsp_t p;
    cmd   <= c;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    p = predict_deque(c);
    if (check_rsp && p !== typed_rsp) begin
      $error("predictor disagrees with table row %p: %p", typed_rsp, p);
      error_count++;
    end
    expected_rsp_q.push_back(check_rsp ? typed_rsp : p);
    @(negedge clk);
  endtask

  // Idle the sender for a random gap after a burst.
  task automatic sender_gap(inout int burst_left);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end else begin
      burst_left--;
    end
  endtask

  // Build a random command, biased toward well-formed positions.
  function automatic sde_pkg::cmd_t random_command(int fill_bias);
    sde_pkg::cmd_t c;
    int n;
    int r;
    n = deque_q.size();
    r = $urandom_range(0, 99);
    c.element_value = $urandom();
    if (r < fill_bias) begin
      c.command = 4'($urandom_range(sde_pkg::CMD_PUSH_FRONT, sde_pkg::CMD_INSERT_AT));
    end else if (r < 97) begin
      c.command = 4'($urandom_range(sde_pkg::CMD_PUSH_FRONT, sde_pkg::CMD_REV_SUFFIX));
    end else begin
      c.command = 4'($urandom_range(9, 15));
    end
    if ($urandom_range(0, 9) == 0) begin
      c.position = 7'($urandom_range(0, 127));
    end else begin
      c.position = 7'($urandom_range(0, n));
    end
    return c;
  endfunction

  // Stimulus.
  initial begin
    dir_row_t dir_tbl[$];
    sde_pkg::cmd_t c;
    sde_pkg::rsp_t none;
    int burst_left;
    int fill_bias;

    error_count = 0;
    rsp_count = 0;
    none = '0;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: empty errors, zero-length reversal, extremes, every command.
    dir_tbl = '{
      '{'{sde_pkg::CMD_POP_FRONT, 32'h0, 7'd0}, 1'b1, '{sde_pkg::ST_EMPTY, 32'h0, 7'd0}},
      '{'{sde_pkg::CMD_POP_BACK, 32'h0, 7'd0}, 1'b1, '{sde_pkg::ST_EMPTY, 32'h0, 7'd0}},
      '{'{sde_pkg::CMD_REMOVE_AT, 32'h0, 7'd64}, 1'b1, '{sde_pkg::ST_EMPTY, 32'h0, 7'd0}},
      '{'{sde_pkg::CMD_ROTATE, 32'h0, 7'd0}, 1'b1, '{sde_pkg::ST_EMPTY, 32'h0, 7'd0}},
      '{'{sde_pkg::CMD_REV_PREFIX, 32'h0, 7'd0}, 1'b1, '{sde_pkg::ST_OK, 32'h0, 7'd0}},
      '{'{sde_pkg::CMD_REV_SUFFIX, 32'h0, 7'd1}, 1'b1, '{sde_pkg::ST_RANGE, 32'h0, 7'd0}},
      '{'{sde_pkg::CMD_INSERT_AT, 32'hFFFF_FFFF, 7'd1}, 1'b1,
        '{sde_pkg::ST_RANGE, 32'h0, 7'd0}},
      '{'{sde_pkg::CMD_INSERT_AT, 32'hFFFF_FFFF, 7'd0}, 1'b1, '{sde_pkg::ST_OK, 32'h0, 7'd1}},
      '{'{sde_pkg::CMD_PUSH_BACK, 32'h0000_0000, 7'd127}, 1'b1,
        '{sde_pkg::ST_OK, 32'h0, 7'd2}},
      '{'{sde_pkg::CMD_PUSH_FRONT, 32'hA5A5_5A5A, 7'd0}, 1'b1, '{sde_pkg::ST_OK, 32'h0, 7'd3}},
      '{'{sde_pkg::CMD_INSERT_AT, 32'h1234_5678, 7'd3}, 1'b0, none},
      '{'{sde_pkg::CMD_INSERT_AT, 32'h8765_4321, 7'd2}, 1'b0, none},
      '{'{sde_pkg::CMD_REV_PREFIX, 32'h0, 7'd5}, 1'b0, none},
      '{'{sde_pkg::CMD_REV_SUFFIX, 32'h0, 7'd4}, 1'b0, none},
      '{'{sde_pkg::CMD_REV_PREFIX, 32'h0, 7'd6}, 1'b1, '{sde_pkg::ST_RANGE, 32'h0, 7'd5}},
      '{'{sde_pkg::CMD_ROTATE, 32'h0, 7'd0}, 1'b0, none},
      '{'{sde_pkg::CMD_REMOVE_AT, 32'h0, 7'd5}, 1'b1, '{sde_pkg::ST_RANGE, 32'h0, 7'd5}},
      '{'{sde_pkg::CMD_REMOVE_AT, 32'h0, 7'd2}, 1'b0, none},
      '{'{sde_pkg::CMD_REMOVE_AT, 32'h0, 7'd0}, 1'b0, none},
      '{'{sde_pkg::CMD_POP_BACK, 32'h0, 7'd0}, 1'b0, none},
      '{'{sde_pkg::CMD_POP_FRONT, 32'h0, 7'd0}, 1'b0, none},
      '{'{4'd9, 32'hFFFF_FFFF, 7'd127}, 1'b1, '{sde_pkg::ST_OK, 32'h0, 7'd1}},
      '{'{4'd15, 32'h0, 7'd0}, 1'b1, '{sde_pkg::ST_OK, 32'h0, 7'd1}}
    };
    foreach (dir_tbl[i]) begin
      send_command(dir_tbl[i].cmd, dir_tbl[i].check_rsp, dir_tbl[i].rsp);
      if (i % 4 == 3) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end

    // Fill to capacity, check the full status, then run phases of varying fill pressure.
    while (deque_q.size() < sde_pkg::Capacity) begin
      c = '{sde_pkg::CMD_PUSH_BACK, 32'($urandom()), 7'd0};
      send_command(c, 1'b0, none);
    end
    send_command('{sde_pkg::CMD_PUSH_FRONT, 32'h0, 7'd0}, 1'b1,
                 '{sde_pkg::ST_FULL, 32'h0, 7'd64});
    send_command('{sde_pkg::CMD_INSERT_AT, 32'h0, 7'd127}, 1'b1,
                 '{sde_pkg::ST_FULL, 32'h0, 7'd64});
    send_command('{sde_pkg::CMD_REV_PREFIX, 32'h0, 7'd64}, 1'b0, none);
    send_command('{sde_pkg::CMD_REV_SUFFIX, 32'h0, 7'd63}, 1'b0, none);
    send_command('{sde_pkg::CMD_REMOVE_AT, 32'h0, 7'd63}, 1'b0, none);
    send_command('{sde_pkg::CMD_INSERT_AT, 32'hFFFF_FFFF, 7'd0}, 1'b0, none);

    // Random part: phases that drain, hover and refill the deque.
    burst_left = $urandom_range(1, 20);
    for (int i = 0; i < NumRandom; i++) begin
      case ((i / 150) % 3)
        0: fill_bias = 10;
        1: fill_bias = 35;
        default: fill_bias = 70;
      endcase
      c = random_command(fill_bias);
      send_command(c, 1'b0, none);
      if (i >= 200 && i < NumRandom - 1) sender_gap(burst_left);
    end
    start <= 1'b0;

    // Drain: wait for outstanding results, then a little longer for stray strobes.
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (4 * sde_pkg::Capacity + 20) @(posedge clk);

    $display("Ran %0d commands; statuses ok/full/empty/range = %0d/%0d/%0d/%0d.",
             rsp_count, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (error_count == 0) begin
      $display("[sequence_deque_engine] OK");
    end else begin
      $display("[sequence_deque_engine] ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #40ms;
    $display("[sequence_deque_engine] ERROR");
    $finish;
  end

endmodule
